// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files of this project.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/scm_pkg.sv =====
// Shared types and fixed widths of the seven-channel cumulative mean core.
// Used by the channel interfaces, the divider and the top level.
package scm_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int MEAN_W      = 32;
	localparam int COUNT_W     = 32;
	// The divisor is the sample count plus one, which can reach 2^32.
	localparam int DIV_W       = COUNT_W + 1;
	localparam int IO_CHANNELS = 7;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [MEAN_W-1:0]   mean_t;
	typedef logic [COUNT_W-1:0]         count_t;
	typedef logic [DIV_W-1:0]           divisor_t;

	typedef enum logic {
		OP_ACCUM = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

endpackage

// ===== design/scm_ifs.sv =====
// Valid/ready channel interfaces of the cumulative mean core: the sample
// channel and the result channel. Depends on scm_pkg.
interface scm_sample_if;
	logic              valid;
	logic              ready;
	scm_pkg::op_t      op;
	scm_pkg::sample_t  accel_x;
	scm_pkg::sample_t  accel_y;
	scm_pkg::sample_t  accel_z;
	scm_pkg::sample_t  gyro_x;
	scm_pkg::sample_t  gyro_y;
	scm_pkg::sample_t  gyro_z;
	scm_pkg::sample_t  temp_raw;

	modport source (output valid, op, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		temp_raw, input ready);
	modport sink (input valid, op, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		temp_raw, output ready);
endinterface

interface scm_result_if;
	logic             valid;
	logic             ready;
	scm_pkg::mean_t   mean_accel_x;
	scm_pkg::mean_t   mean_accel_y;
	scm_pkg::mean_t   mean_accel_z;
	scm_pkg::mean_t   mean_gyro_x;
	scm_pkg::mean_t   mean_gyro_y;
	scm_pkg::mean_t   mean_gyro_z;
	scm_pkg::mean_t   mean_temp;
	scm_pkg::count_t  samples_seen;

	modport source (output valid, mean_accel_x, mean_accel_y, mean_accel_z, mean_gyro_x,
		mean_gyro_y, mean_gyro_z, mean_temp, samples_seen, input ready);
	modport sink (input valid, mean_accel_x, mean_accel_y, mean_accel_z, mean_gyro_x,
		mean_gyro_y, mean_gyro_z, mean_temp, samples_seen, output ready);
endinterface

// ===== design/scm_div.sv =====
// Shared restoring divider: unsigned dividend by the count-plus-one divisor,
// one quotient bit per cycle. Depends on scm_pkg.
module scm_div #(
	parameter int MAG_W = 33
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [MAG_W-1:0]        dividend,
	input  scm_pkg::divisor_t       divisor,
	output logic                    done,
	output logic [MAG_W-1:0]        quotient
);

	localparam int DIV_W = scm_pkg::DIV_W;
	localparam int CNT_W = $clog2(MAG_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsr_q;
	logic [MAG_W-1:0]  quo_q;

	logic [DIV_W:0]    shifted;
	logic              fits;
	logic [DIV_W:0]    trial;

	// The dividend shifts out of the top of quo_q while quotient bits enter below.
	assign shifted = {rem_q, quo_q[MAG_W-1]};
	assign fits    = shifted >= {1'b0, dsr_q};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			// The remainder stays below the divisor, so its top bit drops.
			rem_q <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/seven_channel_cumulative_mean_core.sv =====
// Seven-channel cumulative mean core. An accumulate item runs one division
// for each of LIVE channels, where LIVE = min(CHANNELS, 7), and each division
// yields MAG_W quotient bits, where MAG_W = max(16 + FRAC_BITS, 32) + 1. The
// one shared divider produces one quotient bit per cycle and serves the
// channels one after another. A clear item skips the divider. The block
// accepts one sample item at a time; it is not ready while an item is in
// work, but it does accept a new item while the previous result still
// waits in the output register. Each channel keeps its
// mean in raw counts with FRAC_BITS fraction bits and updates it as
// mean += ((x << FRAC_BITS) - mean) / (n + 1), truncating toward zero and
// saturating to the signed 32-bit range. The sample count saturates at its
// maximum, after which samples divide by 2^32. Every item, clear or
// accumulate, returns one result with all means and the count.
// Depends on scm_pkg, scm_ifs and scm_div.
module seven_channel_cumulative_mean_core #(
	parameter int FRAC_BITS = 16,
	parameter int CHANNELS  = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	scm_sample_if.sink    sample,
	scm_result_if.source  result
);

	localparam int IO     = scm_pkg::IO_CHANNELS;
	localparam int MEAN_W = scm_pkg::MEAN_W;
	// Only the first seven channels have sample fields; others stay zero.
	localparam int LIVE   = (CHANNELS < IO) ? CHANNELS : IO;
	localparam int CH_W   = (LIVE > 1) ? $clog2(LIVE) : 1;
	localparam int X_W    = scm_pkg::SAMPLE_W + FRAC_BITS;
	localparam int DIFF_W = ((X_W > MEAN_W) ? X_W : MEAN_W) + 1;
	localparam int MAG_W  = DIFF_W;
	localparam int SQ_W   = MAG_W + 1;
	localparam int SUM_W  = SQ_W + 1;

	// One-hot sequencer states.
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_LOAD = 5'b00010,
		S_WAIT = 5'b00100,
		S_UPD  = 5'b01000,
		S_PUB  = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [CH_W-1:0]          ch_q;
	scm_pkg::count_t          count_q;
	scm_pkg::mean_t           mean_q [LIVE];
	logic                     res_valid_q;

	scm_pkg::sample_t         samp_q [LIVE];
	logic                     neg_q;
	logic signed [SQ_W-1:0]   quo_s1;
	scm_pkg::mean_t           res_mean_q [IO];
	scm_pkg::count_t          res_count_q;

	scm_pkg::sample_t         in_samp [IO];
	scm_pkg::mean_t           mean_out [IO];
	logic                     accept;
	logic                     pub_fire;
	logic                     last_ch;
	logic signed [X_W-1:0]    x_scaled;
	logic signed [DIFF_W-1:0] diff;
	logic [MAG_W-1:0]         diff_mag;
	logic signed [SQ_W-1:0]   quo_ext;
	logic signed [SUM_W-1:0]  sum;
	logic [SUM_W-MEAN_W:0]    sum_hi;
	scm_pkg::mean_t           mean_sat;
	logic                     div_start;
	logic                     div_done;
	logic [MAG_W-1:0]         div_quo;
	scm_pkg::divisor_t        divisor;

	// The sample fields in channel order.
	assign in_samp[0] = sample.accel_x;
	assign in_samp[1] = sample.accel_y;
	assign in_samp[2] = sample.accel_z;
	assign in_samp[3] = sample.gyro_x;
	assign in_samp[4] = sample.gyro_y;
	assign in_samp[5] = sample.gyro_z;
	assign in_samp[6] = sample.temp_raw;

	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign pub_fire     = (state_q == S_PUB) && (!res_valid_q || result.ready);
	assign last_ch      = (ch_q == CH_W'(LIVE - 1));

	// Difference between the scaled sample and the current mean of this channel.
	assign x_scaled = X_W'(samp_q[ch_q]) <<< FRAC_BITS;
	assign diff     = DIFF_W'(x_scaled) - DIFF_W'(mean_q[ch_q]);
	assign diff_mag = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
	assign divisor  = {1'b0, count_q} + 1'b1;

	assign div_start = (state_q == S_LOAD);

	scm_div #(
		.MAG_W(MAG_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff_mag),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Apply the signed quotient, then clamp to the signed 32-bit range when the
	// bits above the mean's sign bit disagree.
	assign quo_ext = signed'({1'b0, div_quo});
	assign sum     = SUM_W'(mean_q[ch_q]) + SUM_W'(quo_s1);
	assign sum_hi  = sum[SUM_W-1:MEAN_W-1];

	always_comb begin
		if ((sum_hi == '0) || (sum_hi == '1)) begin
			mean_sat = sum[MEAN_W-1:0];
		end else if (sum[SUM_W-1]) begin
			mean_sat = {1'b1, {(MEAN_W-1){1'b0}}};
		end else begin
			mean_sat = {1'b0, {(MEAN_W-1){1'b1}}};
		end
	end

	// Mean fields without a channel read zero.
	for (genvar g = 0; g < IO; g++) begin : g_out
		if (g < LIVE) begin : g_live
			assign mean_out[g] = mean_q[g];
		end else begin : g_none
			assign mean_out[g] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < LIVE; i++) begin
				mean_q[i] <= '0;
			end
		end else begin
			if (pub_fire) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ch_q <= '0;
						if (sample.op == scm_pkg::OP_CLEAR) begin
							count_q <= '0;
							for (int i = 0; i < LIVE; i++) begin
								mean_q[i] <= '0;
							end
							state_q <= S_PUB;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					mean_q[ch_q] <= mean_sat;
					if (last_ch) begin
						if (count_q != '1) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= S_PUB;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_PUB: begin
					if (pub_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < LIVE; i++) begin
				samp_q[i] <= in_samp[i];
			end
		end
		if (state_q == S_LOAD) begin
			neg_q <= diff[DIFF_W-1];
		end
		if ((state_q == S_WAIT) && div_done) begin
			quo_s1 <= neg_q ? -quo_ext : quo_ext;
		end
		if (pub_fire) begin
			for (int i = 0; i < IO; i++) begin
				res_mean_q[i] <= mean_out[i];
			end
			res_count_q <= count_q;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.mean_accel_x = res_mean_q[0];
	assign result.mean_accel_y = res_mean_q[1];
	assign result.mean_accel_z = res_mean_q[2];
	assign result.mean_gyro_x  = res_mean_q[3];
	assign result.mean_gyro_y  = res_mean_q[4];
	assign result.mean_gyro_z  = res_mean_q[5];
	assign result.mean_temp    = res_mean_q[6];
	assign result.samples_seen = res_count_q;

endmodule

// ===== design/scm_checker.sv =====
// Port-level checker for the cumulative mean core, bound to the top level.
// Depends on scm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scm_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic             out_valid,
	input  logic             out_ready,
	input  scm_pkg::mean_t   mean_ax,
	input  scm_pkg::mean_t   mean_ay,
	input  scm_pkg::mean_t   mean_az,
	input  scm_pkg::mean_t   mean_gx,
	input  scm_pkg::mean_t   mean_gy,
	input  scm_pkg::mean_t   mean_gz,
	input  scm_pkg::mean_t   mean_tp,
	input  scm_pkg::count_t  count
);

	// A result that waits keeps its count.
	`SCM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(count), "result changed while stalled")

	// The core works on one item at a time.
	`SCM_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready, "ready stayed high after an item was taken")

	// A zero count only follows a clear, so every mean must be zero with it.
	`SCM_ASSERT_IMPLY(a_zero_count, clk, arst_n, out_valid && (count == '0), (mean_ax == '0) && (mean_ay == '0) && (mean_az == '0) && (mean_gx == '0) && (mean_gy == '0) && (mean_gz == '0) && (mean_tp == '0), "nonzero mean with zero count")

endmodule

bind seven_channel_cumulative_mean_core scm_checker u_scm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.mean_ax   (result.mean_accel_x),
	.mean_ay   (result.mean_accel_y),
	.mean_az   (result.mean_accel_z),
	.mean_gx   (result.mean_gyro_x),
	.mean_gy   (result.mean_gyro_y),
	.mean_gz   (result.mean_gyro_z),
	.mean_tp   (result.mean_temp),
	.count     (result.samples_seen)
);
